[design/cvsl_pkg.sv]
// Shared types and constants for the composite video sync line counter.
package cvsl_pkg;

  // Configuration register indexes.
  localparam logic [2:0] RegVideoStandard = 3'd0;
  localparam logic [2:0] RegHsyncTicks    = 3'd1;
  localparam logic [2:0] RegEqualTicks    = 3'd2;
  localparam logic [2:0] RegBroadTicks    = 3'd3;
  localparam logic [2:0] RegLinePeriod    = 3'd4;
  localparam logic [2:0] RegTolerance     = 3'd5;
  localparam logic [2:0] RegBlankLines    = 3'd6;

  localparam int TickWidth = 16;
  localparam int CountWidth = 8;

  // Vertical-interval capture phases.
  typedef enum logic [2:0] {
    PH_UNKNOWN   = 3'd0,
    PH_FIRST_EQ  = 3'd1,
    PH_BROAD     = 3'd2,
    PH_SECOND_EQ = 3'd3,
    PH_LINES     = 3'd4
  } phase_t;

  // Configuration registers.
  typedef struct packed {
    logic                    pal;
    logic [TickWidth-1:0]    hsync_ticks;
    logic [TickWidth-1:0]    equal_ticks;
    logic [TickWidth-1:0]    broad_ticks;
    logic [TickWidth-1:0]    line_ticks;
    logic [TickWidth-1:0]    tolerance;
    logic [CountWidth-1:0]   skip_lines;
  } cfg_t;

  // Classification of one pulse.
  typedef struct packed {
    logic                 hsync;
    logic                 equal;
    logic                 broad;
    logic                 prev_hsync;
    logic                 period_ok;
    logic [TickWidth-1:0] width;
  } match_t;

  // One result word.
  typedef struct packed {
    logic                 locked;
    phase_t               phase;
    logic                 field_odd;
    logic [TickWidth-1:0] active_lines;
    logic                 frame_done;
    logic [TickWidth-1:0] frame_lines;
  } result_t;

endpackage

[design/composite_video_sync_line_counter_unit.sv]
// Top level of the composite video sync line counter.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_ready     rise_tick, fall_tick
//   out      output     out_valid / out_ready   locked .. frame_lines
//   cfg      input      cfg_write               cfg_index, cfg_data
//
// A word passes through two registers in the block: the input register, then
// the result register, with the state update between them. One word is accepted
// every cycle while the result register is not stalled.
// Reset is synchronous and returns the tracker to the unknown phase.
// A stalled result holds in its register; the input register still takes a
// word while the result waits, and stalls only when both are full.
module composite_video_sync_line_counter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] rise_tick,
  input  logic [15:0] fall_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        locked,
  output logic [2:0]  capture_phase,
  output logic        field_odd,
  output logic [15:0] active_lines,
  output logic        frame_done,
  output logic [15:0] frame_lines,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cvsl_pkg::cfg_t    cfg;
  cvsl_pkg::match_t  match;
  cvsl_pkg::result_t result;
  cvsl_pkg::result_t out_word;

  logic        s1_valid;
  logic [15:0] s1_rise;
  logic [15:0] s1_fall;
  logic [15:0] previous_width;
  logic [15:0] previous_rise;
  logic        advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        cvsl_pkg::RegVideoStandard: cfg.pal         <= cfg_data[0];
        cvsl_pkg::RegHsyncTicks:    cfg.hsync_ticks <= cfg_data;
        cvsl_pkg::RegEqualTicks:    cfg.equal_ticks <= cfg_data;
        cvsl_pkg::RegBroadTicks:    cfg.broad_ticks <= cfg_data;
        cvsl_pkg::RegLinePeriod:    cfg.line_ticks  <= cfg_data;
        cvsl_pkg::RegTolerance:     cfg.tolerance   <= cfg_data;
        cvsl_pkg::RegBlankLines:    cfg.skip_lines  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_rise <= rise_tick;
      s1_fall <= fall_tick;
    end
  end

  // Pulse matcher.
  cvsl_classify u_classify (
    .cfg            (cfg),
    .rise_tick      (s1_rise),
    .fall_tick      (s1_fall),
    .previous_width (previous_width),
    .previous_rise  (previous_rise),
    .match          (match)
  );

  // State tracker.
  cvsl_tracker u_tracker (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .cfg            (cfg),
    .rise_tick      (s1_rise),
    .match          (match),
    .previous_width (previous_width),
    .previous_rise  (previous_rise),
    .result         (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  assign locked        = out_word.locked;
  assign capture_phase = out_word.phase;
  assign field_odd     = out_word.field_odd;
  assign active_lines  = out_word.active_lines;
  assign frame_done    = out_word.frame_done;
  assign frame_lines   = out_word.frame_lines;

endmodule

[design/cvsl_classify.sv]
// Pulse width and line period matcher against the nominal tick values.
module cvsl_classify (
  input  cvsl_pkg::cfg_t                    cfg,
  input  logic [cvsl_pkg::TickWidth-1:0]    rise_tick,
  input  logic [cvsl_pkg::TickWidth-1:0]    fall_tick,
  input  logic [cvsl_pkg::TickWidth-1:0]    previous_width,
  input  logic [cvsl_pkg::TickWidth-1:0]    previous_rise,
  output cvsl_pkg::match_t                  match
);

  logic [cvsl_pkg::TickWidth-1:0] width;
  logic [cvsl_pkg::TickWidth-1:0] period;

  // True when the value lies within the tolerance of the nominal value.
  function automatic logic near_match(input logic [cvsl_pkg::TickWidth-1:0] value,
                                      input logic [cvsl_pkg::TickWidth-1:0] nominal,
                                      input logic [cvsl_pkg::TickWidth-1:0] tol);
    logic [cvsl_pkg::TickWidth-1:0] diff;
    diff = (value >= nominal) ? (value - nominal) : (nominal - value);
    return diff <= tol;
  endfunction

  // Widths wrap with the 16-bit timer.
  assign width  = fall_tick - rise_tick;
  assign period = fall_tick - previous_rise;

  // All windows are tested in parallel; priority is applied by the tracker.
  always_comb begin
    match.width      = width;
    match.hsync      = near_match(width, cfg.hsync_ticks, cfg.tolerance);
    match.equal      = near_match(width, cfg.equal_ticks, cfg.tolerance);
    match.broad      = near_match(width, cfg.broad_ticks, cfg.tolerance);
    match.prev_hsync = near_match(previous_width, cfg.hsync_ticks, cfg.tolerance);
    match.period_ok  = near_match(period, cfg.line_ticks, cfg.tolerance);
  end

endmodule

[design/cvsl_tracker.sv]
// Vertical-interval state tracker with line, active-line and field counters.
module cvsl_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  cvsl_pkg::cfg_t                    cfg,
  input  logic [cvsl_pkg::TickWidth-1:0]    rise_tick,
  input  cvsl_pkg::match_t                  match,
  output logic [cvsl_pkg::TickWidth-1:0]    previous_width,
  output logic [cvsl_pkg::TickWidth-1:0]    previous_rise,
  output cvsl_pkg::result_t                 result
);

  localparam logic [cvsl_pkg::CountWidth-1:0] FailLimit = 8'd10;
  localparam logic [cvsl_pkg::CountWidth-1:0] FailMax   = 8'd255;

  cvsl_pkg::phase_t phase, phase_next;
  logic odd_field, odd_field_next;
  logic pal_odd_ready, pal_odd_ready_next;
  logic [cvsl_pkg::TickWidth-1:0] line_count, line_count_next;
  logic [cvsl_pkg::TickWidth-1:0] active_count, active_count_next;
  logic [cvsl_pkg::CountWidth-1:0] blank_remaining, blank_remaining_next;
  logic [cvsl_pkg::CountWidth-1:0] failure_count, failure_count_next;
  logic [cvsl_pkg::CountWidth-1:0] equalizing_hits, equalizing_hits_next;
  logic [cvsl_pkg::CountWidth-1:0] broad_hits, broad_hits_next;
  logic [cvsl_pkg::CountWidth-1:0] hsync_hits, hsync_hits_next;
  logic done;
  logic [cvsl_pkg::TickWidth-1:0] logged;

  // Next-state logic for one pulse.
  always_comb begin
    phase_next           = phase;
    odd_field_next       = odd_field;
    pal_odd_ready_next   = pal_odd_ready;
    line_count_next      = line_count;
    active_count_next    = active_count;
    blank_remaining_next = blank_remaining;
    failure_count_next   = failure_count;
    equalizing_hits_next = equalizing_hits;
    broad_hits_next      = broad_hits;
    hsync_hits_next      = hsync_hits;
    done                 = 1'b0;
    logged               = '0;

    if (phase != cvsl_pkg::PH_UNKNOWN) begin
      if (match.hsync) begin
        // Horizontal sync: end of vertical interval or one more line.
        if (phase == cvsl_pkg::PH_SECOND_EQ && hsync_hits != '0) begin
          hsync_hits_next      = '0;
          line_count_next      = line_count + (cfg.pal ? 16'd4 : 16'd5);
          blank_remaining_next = cfg.skip_lines;
          phase_next           = cvsl_pkg::PH_LINES;
        end else if (phase == cvsl_pkg::PH_LINES) begin
          hsync_hits_next = '0;
          line_count_next = line_count + 16'd1;
          if (blank_remaining == '0) begin
            active_count_next = active_count + 16'd1;
          end else begin
            blank_remaining_next = blank_remaining - 8'd1;
          end
        end else if (phase == cvsl_pkg::PH_SECOND_EQ) begin
          hsync_hits_next = hsync_hits + 8'd2;
        end else begin
          hsync_hits_next = hsync_hits + 8'd1;
        end
      end else if (match.equal) begin
        // Equalizing pulse: start or end of the broad pulse group.
        if (phase == cvsl_pkg::PH_LINES && equalizing_hits != '0) begin
          equalizing_hits_next = '0;
          if (cfg.pal) begin
            pal_odd_ready_next = odd_field;
          end else if (!odd_field) begin
            odd_field_next     = 1'b1;
            logged             = line_count;
            done               = 1'b1;
            line_count_next    = '0;
            failure_count_next = '0;
          end else begin
            odd_field_next = 1'b0;
          end
          active_count_next = '0;
          phase_next        = cvsl_pkg::PH_FIRST_EQ;
        end else if (phase == cvsl_pkg::PH_BROAD && equalizing_hits != '0) begin
          equalizing_hits_next = '0;
          line_count_next      = line_count + 16'd3;
          phase_next           = cvsl_pkg::PH_SECOND_EQ;
        end else begin
          equalizing_hits_next = equalizing_hits + 8'd1;
        end
      end else if (match.broad) begin
        // Broad pulse: start of the broad group; field decision under PAL rules.
        if (phase == cvsl_pkg::PH_FIRST_EQ && broad_hits != '0) begin
          broad_hits_next = '0;
          if (cfg.pal) begin
            if (pal_odd_ready) begin
              odd_field_next     = 1'b0;
              logged             = line_count + 16'd2;
              done               = 1'b1;
              line_count_next    = '0;
              failure_count_next = '0;
            end else begin
              odd_field_next  = 1'b1;
              line_count_next = line_count + 16'd3;
            end
          end else begin
            line_count_next = line_count + 16'd3;
          end
          phase_next = cvsl_pkg::PH_BROAD;
        end else begin
          broad_hits_next = broad_hits + 8'd1;
        end
      end else begin
        // Unclassified pulse: count toward loss of lock.
        if (failure_count != FailMax) begin
          failure_count_next = failure_count + 8'd1;
        end
        if (failure_count_next > FailLimit) begin
          phase_next = cvsl_pkg::PH_UNKNOWN;
        end
      end
    end else if (match.equal && match.prev_hsync) begin
      // Lock on the first equalizing pulse after a line sync.
      if (match.period_ok) begin
        if (cfg.pal) begin
          pal_odd_ready_next = 1'b0;
        end else begin
          odd_field_next     = 1'b1;
          line_count_next    = '0;
          failure_count_next = '0;
        end
      end
      active_count_next = '0;
      phase_next        = cvsl_pkg::PH_FIRST_EQ;
    end
  end

  // Result of this pulse, taken from the updated state.
  always_comb begin
    result.locked       = (phase_next != cvsl_pkg::PH_UNKNOWN);
    result.phase        = phase_next;
    result.field_odd    = odd_field_next;
    result.active_lines = active_count_next;
    result.frame_done   = done;
    result.frame_lines  = logged;
  end

  // State registers, updated once per word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= cvsl_pkg::PH_UNKNOWN;
      previous_width  <= '0;
      previous_rise   <= '0;
      odd_field       <= 1'b0;
      pal_odd_ready   <= 1'b0;
      line_count      <= '0;
      active_count    <= '0;
      blank_remaining <= '0;
      failure_count   <= '0;
      equalizing_hits <= '0;
      broad_hits      <= '0;
      hsync_hits      <= '0;
    end else if (step) begin
      phase           <= phase_next;
      previous_width  <= match.width;
      previous_rise   <= rise_tick;
      odd_field       <= odd_field_next;
      pal_odd_ready   <= pal_odd_ready_next;
      line_count      <= line_count_next;
      active_count    <= active_count_next;
      blank_remaining <= blank_remaining_next;
      failure_count   <= failure_count_next;
      equalizing_hits <= equalizing_hits_next;
      broad_hits      <= broad_hits_next;
      hsync_hits      <= hsync_hits_next;
    end
  end

endmodule
